// File: rtl/core/bss_pkg.sv
package bss_pkg;

	localparam int unsigned RATE_W = 10;
	localparam int unsigned TEMP_W = 10;
	localparam int unsigned SEC_W  = 8;
	localparam int unsigned NUM_RATES = 4;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_START = 2'd1,
		OP_DOWN  = 2'd2,
		OP_UP    = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'd0,
		PH_TEST  = 4'd1,
		PH_FAN   = 4'd2,
		PH_GLOW  = 4'd3,
		PH_PRIME = 4'd4,
		PH_FLAME = 4'd5,
		PH_RUN   = 4'd6,
		PH_STOP  = 4'd7,
		PH_FAIL  = 4'd8
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE     = 3'd0,
		ST_STARTING = 3'd1,
		ST_WORKING  = 3'd2,
		ST_STOPPING = 3'd3,
		ST_LOW_TEMP = 3'd4,
		ST_NO_FLAME = 3'd5,
		ST_OVERHEAT = 3'd6
	} status_t;

	localparam logic [1:0] CFG_RATE1 = 2'd0;
	localparam logic [1:0] CFG_RATE2 = 2'd1;
	localparam logic [1:0] CFG_RATE3 = 2'd2;
	localparam logic [1:0] CFG_RATE4 = 2'd3;

	localparam logic [RATE_W-1:0] RATE1_RST = 10'd160;
	localparam logic [RATE_W-1:0] RATE2_RST = 10'd230;
	localparam logic [RATE_W-1:0] RATE3_RST = 10'd350;
	localparam logic [RATE_W-1:0] RATE4_RST = 10'd450;

	localparam logic [2:0] MODE_MAX = 3'd4;
	localparam logic [2:0] FAN_FULL = 3'd4;
	localparam logic [2:0] FAN_LOW  = 3'd1;

	localparam logic [SEC_W-1:0] SEC_MAX       = 8'd255;
	localparam logic [SEC_W-1:0] FAN_SECS      = 8'd15;
	localparam logic [SEC_W-1:0] GLOW_SECS     = 8'd20;
	localparam logic [SEC_W-1:0] PRIME_SECS    = 8'd20;
	localparam logic [SEC_W-1:0] FLAME_SECS    = 8'd90;
	localparam logic [SEC_W-1:0] RUN_SECS      = 8'd10;
	localparam logic [SEC_W-1:0] COLD_LIMIT    = 8'd5;
	localparam logic [SEC_W-1:0] STOP_GLOW_ON  = 8'd60;
	localparam logic [SEC_W-1:0] STOP_GLOW_OFF = 8'd90;
	localparam logic [SEC_W-1:0] STOP_SECS     = 8'd180;
	localparam logic [SEC_W-1:0] FAIL_GLOW_ON  = 8'd30;
	localparam logic [SEC_W-1:0] FAIL_GLOW_OFF = 8'd60;
	localparam logic [SEC_W-1:0] FAIL_SECS     = 8'd90;

	localparam logic [TEMP_W-1:0] FLAME_TEMP = 10'd30;
	localparam logic [TEMP_W-1:0] COLD_TEMP  = 10'd20;

	typedef logic [NUM_RATES-1:0][RATE_W-1:0] rate_cfg_t;

	typedef struct packed {
		phase_t           phase;
		logic [SEC_W-1:0] sec;
		logic [SEC_W-1:0] cold;
		status_t          status;
		logic [2:0]       fan;
		logic             glow;
		logic [2:0]       pump_mode;
		logic [2:0]       mode;
		logic             req;
	} bss_state_t;

endpackage

// File: rtl/core/bss_step.sv
module bss_step import bss_pkg::*; (
	input  bss_state_t        cur,
	input  op_t               op,
	input  logic [TEMP_W-1:0] fire_temp,
	input  logic              overheat,
	output bss_state_t        nxt
);

	logic [SEC_W-1:0] t;
	logic [2:0]       m;

	always_comb begin
		nxt = cur;
		t = (cur.sec < SEC_MAX) ? cur.sec + 8'd1 : cur.sec;
		m = (cur.mode > MODE_MAX) ? MODE_MAX : cur.mode;
		case (op)
			OP_TICK: begin
				nxt.sec = t;
				case (cur.phase)
					PH_IDLE: begin
						nxt.sec = '0;
					end
					PH_TEST: begin
						nxt.phase = PH_FAN;
						nxt.sec = '0;
					end
					PH_FAN: begin
						if (t == 8'd1) begin
							nxt.fan = FAN_FULL;
							nxt.status = ST_STARTING;
						end
						if (t > FAN_SECS) begin
							nxt.phase = PH_GLOW;
							nxt.sec = '0;
						end
					end
					PH_GLOW: begin
						if (t == 8'd1) nxt.glow = 1'b1;
						if (t == GLOW_SECS) begin
							nxt.phase = PH_PRIME;
							nxt.sec = '0;
						end
					end
					PH_PRIME: begin
						if (t == 8'd1) nxt.pump_mode = MODE_MAX;
						if (t == PRIME_SECS) begin
							nxt.phase = PH_FLAME;
							nxt.sec = '0;
						end
					end
					PH_FLAME: begin
						if (t < FLAME_SECS) begin
							if (fire_temp >= FLAME_TEMP) begin
								nxt.phase = PH_RUN;
								nxt.sec = '0;
							end
						end else begin
							nxt.status = ST_NO_FLAME;
							nxt.phase = PH_FAIL;
							nxt.sec = '0;
						end
					end
					PH_RUN: begin
						if (t == 8'd1) begin
							nxt.status = ST_WORKING;
							nxt.glow = 1'b0;
						end
						if (overheat) begin
							nxt.status = ST_OVERHEAT;
							nxt.sec = '0;
							nxt.pump_mode = '0;
							nxt.phase = PH_STOP;
						end
						if (fire_temp < COLD_TEMP && cur.cold < SEC_MAX)
							nxt.cold = cur.cold + 8'd1;
						if (fire_temp > FLAME_TEMP) nxt.cold = '0;
						if (nxt.cold > COLD_LIMIT) begin
							nxt.status = ST_LOW_TEMP;
							nxt.sec = '0;
							nxt.pump_mode = '0;
							nxt.phase = PH_STOP;
						end
						if (t > RUN_SECS) begin
							nxt.sec = '0;
							if (cur.fan != m) begin
								nxt.fan = m;
								nxt.pump_mode = m;
							end
							if (m == 3'd0) begin
								nxt.pump_mode = '0;
								nxt.phase = PH_STOP;
							end
						end
					end
					PH_STOP: begin
						if (t == 8'd1) begin
							nxt.status = ST_STOPPING;
							nxt.pump_mode = '0;
							nxt.fan = FAN_LOW;
						end
						if (t == STOP_GLOW_ON) nxt.glow = 1'b1;
						if (t > STOP_GLOW_OFF) nxt.glow = 1'b0;
						if (t > STOP_SECS) begin
							nxt.fan = '0;
							nxt.sec = '0;
							nxt.phase = PH_IDLE;
							nxt.req = 1'b0;
						end
					end
					PH_FAIL: begin
						if (t == 8'd1) begin
							nxt.pump_mode = '0;
							nxt.glow = 1'b0;
							nxt.fan = FAN_LOW;
						end
						if (t == FAIL_GLOW_ON) nxt.glow = 1'b1;
						if (t > FAIL_GLOW_OFF) nxt.glow = 1'b0;
						if (t > FAIL_SECS) begin
							nxt.fan = '0;
							nxt.sec = '0;
							nxt.phase = PH_IDLE;
						end
					end
					default: begin
						nxt.phase = PH_IDLE;
						nxt.sec = '0;
					end
				endcase
			end
			OP_START: begin
				nxt.req = 1'b1;
				if (!cur.req) nxt.mode = MODE_MAX;
			end
			OP_DOWN: begin
				if (cur.req) begin
					if (cur.mode <= 3'd1) begin
						nxt.mode = '0;
						nxt.req = 1'b0;
					end else begin
						nxt.mode = m - 3'd1;
					end
				end
			end
			OP_UP: begin
				if (cur.req) nxt.mode = (cur.mode >= MODE_MAX) ? MODE_MAX : cur.mode + 3'd1;
			end
			default: begin
				nxt = cur;
			end
		endcase
		// re-evaluation after a START command, or an UP or DOWN command while a run is requested
		if (op != OP_TICK && (op == OP_START || cur.req)) begin
			if (nxt.req) begin
				if (nxt.phase == PH_IDLE) nxt.phase = PH_TEST;
			end else if (nxt.phase == PH_RUN) begin
				nxt.phase = PH_STOP;
			end
		end
	end

endmodule

// File: rtl/core/bss_out.sv
module bss_out import bss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  bss_state_t        nxt,
	input  rate_cfg_t         rates,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [3:0]        phase,
	output logic [2:0]        status,
	output logic [2:0]        fan_speed,
	output logic              glow_on,
	output logic              pump_enable,
	output logic [RATE_W-1:0] pump_rate,
	output logic [2:0]        heat_mode,
	output logic              run_request
);

	logic [RATE_W-1:0] rate_sel;

	always_comb begin
		case (nxt.pump_mode)
			3'd1:    rate_sel = rates[CFG_RATE1];
			3'd2:    rate_sel = rates[CFG_RATE2];
			3'd3:    rate_sel = rates[CFG_RATE3];
			3'd4:    rate_sel = rates[CFG_RATE4];
			default: rate_sel = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			phase       <= nxt.phase;
			status      <= nxt.status;
			fan_speed   <= nxt.fan;
			glow_on     <= nxt.glow;
			pump_enable <= (nxt.pump_mode != 3'd0);
			pump_rate   <= rate_sel;
			heat_mode   <= nxt.mode;
			run_request <= nxt.req;
		end
	end

endmodule

// File: rtl/core/burner_start_stop_sequencer.sv
// Channel  Handshake              Payload
// in       in_valid / in_ready    op, fire_temp, overheat
// out      out_valid / out_ready  phase, status, fan_speed, glow_on, pump_enable,
//                                 pump_rate, heat_mode, run_request
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One transaction per cycle while in_ready is high: the sequencer state updates at input
// accept and the result appears in the output register the next cycle.
// in_ready is high whenever the output register is empty or being drained.
// cfg_ready is always high. Reset restores the power-on rates and idle state.
module burner_start_stop_sequencer import bss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        op,
	input  logic [TEMP_W-1:0] fire_temp,
	input  logic              overheat,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [3:0]        phase,
	output logic [2:0]        status,
	output logic [2:0]        fan_speed,
	output logic              glow_on,
	output logic              pump_enable,
	output logic [RATE_W-1:0] pump_rate,
	output logic [2:0]        heat_mode,
	output logic              run_request,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [RATE_W-1:0] cfg_data
);

	bss_state_t st_q;
	bss_state_t st_nxt;
	rate_cfg_t  rates_q;
	logic       accept;

	assign in_ready  = !out_valid || out_ready;
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;

	bss_step u_step (
		.cur       (st_q),
		.op        (op_t'(op)),
		.fire_temp (fire_temp),
		.overheat  (overheat),
		.nxt       (st_nxt)
	);

	bss_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (accept),
		.nxt         (st_nxt),
		.rates       (rates_q),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.phase       (phase),
		.status      (status),
		.fan_speed   (fan_speed),
		.glow_on     (glow_on),
		.pump_enable (pump_enable),
		.pump_rate   (pump_rate),
		.heat_mode   (heat_mode),
		.run_request (run_request)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: PH_IDLE, status: ST_IDLE, default: '0};
		end else if (accept) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rates_q[CFG_RATE1] <= RATE1_RST;
			rates_q[CFG_RATE2] <= RATE2_RST;
			rates_q[CFG_RATE3] <= RATE3_RST;
			rates_q[CFG_RATE4] <= RATE4_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_RATE1: rates_q[CFG_RATE1] <= cfg_data;
				CFG_RATE2: rates_q[CFG_RATE2] <= cfg_data;
				CFG_RATE3: rates_q[CFG_RATE3] <= cfg_data;
				CFG_RATE4: rates_q[CFG_RATE4] <= cfg_data;
				default: ;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("accepted transaction produced no result");

	a_glow_phase: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.glow |-> (st_q.phase >= PH_GLOW))
		else $error("glow plug on outside heating phases");

	a_fan_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.fan <= FAN_FULL) && (st_q.mode <= MODE_MAX) && (st_q.pump_mode <= MODE_MAX))
		else $error("fan, mode or pump mode out of range");
`endif

endmodule
